// ===== rtl/core/pidc_pkg.sv =====
// Shared types and constants for the clamped PID controller.
`timescale 1ns / 1ps

package pidc_pkg;

    localparam int DATA_W  = 32;
    localparam int LIM_W   = 31;
    localparam int MUL_W   = 33;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_W  = 24;
    localparam int TERM_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = 64;
    localparam int DIVD_W  = 64;
    localparam int DIVS_W  = 32;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_CYCLES = DIVD_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
    localparam int CFG_IDX_W  = 3;

    localparam logic [SUM_W-1:0] D_SAT = 64'h4000_0000_0000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT   = 3'd5;

    localparam logic [DATA_W-1:0] RST_SAMPLE_PERIOD = 32'd167772;
    localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT   = 31'd65536000;
    localparam logic [LIM_W-1:0]  RST_INTEG_LIMIT   = 31'd65536000;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_DELTA,
        S_MUL_PROP,
        S_MUL_INTEG,
        S_MUL_DERIV,
        S_DIV_LOAD,
        S_DIV_RUN,
        S_CLAMP
    } state_t;

endpackage

// ===== rtl/core/pidc_mul.sv =====
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module pidc_mul
    import pidc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/pidc_div.sv =====
// Iterative unsigned restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps

module pidc_div
    import pidc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIVS_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVS_W:0]   r1, r2;
    logic              q1, q0;
    logic [DIVS_W-1:0] rem1, rem2;

    always_comb
    begin
        r1   = {rem_reg, quo_reg[DIVD_W-1]};
        q1   = (r1 >= {1'b0, dvs_reg});
        rem1 = q1 ? DIVS_W'(r1 - {1'b0, dvs_reg}) : r1[DIVS_W-1:0];
        r2   = {rem1, quo_reg[DIVD_W-2]};
        q0   = (r2 >= {1'b0, dvs_reg});
        rem2 = q0 ? DIVS_W'(r2 - {1'b0, dvs_reg}) : r2[DIVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVD_W-3:0], q1, q0};
            rem_reg <= rem2;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/pid_controller_clamped.sv =====
// Clamped PID controller top level: registers, sequencer and result stage.
//
// channel  | direction | handshake                    | payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: setpoint, measured
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: drive; tuser: clamp flags
// cfg      | in        | cfg_valid/cfg_ready          | cfg_index, cfg_data
//
// Steps per item: accept, four passes through the shared 33x33 multiplier,
// divider load, the run of the two-bit-per-cycle divider, sum, clamp.
// The clamp cycle waits while the result register is still full.
// Reset clears the integral, the previous error and loads the register defaults.
// s_axis_tready is high only while the sequencer is idle.
`timescale 1ns / 1ps

module pid_controller_clamped
    import pidc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [63:0]          s_axis_tdata,   // [31:0] setpoint, [63:32] measured
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [31:0] drive
    output logic [1:0]           m_axis_tuser,   // [0] drive_clamped, [1] integ_clamped
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    // configuration
    logic [DATA_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg, sample_period_reg;
    logic [LIM_W-1:0]  drive_limit_reg, integ_limit_reg;

    // datapath state
    state_t                   state_reg, state_next;
    logic signed [DATA_W-1:0] err_reg;
    logic signed [DATA_W-1:0] prev_error_reg;
    logic signed [DATA_W-1:0] integ_acc_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     dneg_reg;
    logic                     ihit_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    logic                     out_valid_reg;
    logic [DATA_W-1:0]        out_drive_reg;
    logic                     out_dhit_reg;
    logic                     out_ihit_reg;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] term;
    logic                     div_start;
    logic                     div_done;
    logic [DIVD_W-1:0]        quotient;
    logic [DIVS_W-1:0]        divisor;

    logic                     in_accept;
    logic                     out_free;
    logic signed [DATA_W:0]   err_wide;
    logic signed [DATA_W-1:0] err_sat;
    logic signed [DATA_W:0]   diff;
    logic [DATA_W:0]          diff_abs;
    logic signed [TERM_W:0]   integ_tmp;
    logic signed [TERM_W:0]   ilim_ext;
    logic [SUM_W-1:0]         q_sat;
    logic signed [SUM_W-1:0]  dterm;
    logic signed [SUM_W-1:0]  dlim_ext;

    pidc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod[DIVD_W-1:0]),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;
    assign term      = prod[PROD_W-1:FRAC_W];
    assign divisor   = (sample_period_reg == '0) ? DIVS_W'(1) : sample_period_reg;

    always_comb
    begin
        err_wide = {s_axis_tdata[31], s_axis_tdata[31:0]}
                 - {s_axis_tdata[63], s_axis_tdata[63:32]};
        if (err_wide[DATA_W] != err_wide[DATA_W-1])
            err_sat = err_wide[DATA_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        else
            err_sat = err_wide[DATA_W-1:0];

        diff     = {err_reg[DATA_W-1], err_reg} - {prev_error_reg[DATA_W-1], prev_error_reg};
        diff_abs = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;

        integ_tmp = (TERM_W+1)'(integ_acc_reg) + (TERM_W+1)'(term);
        ilim_ext  = (TERM_W+1)'({1'b0, integ_limit_reg});

        q_sat    = (quotient > D_SAT) ? D_SAT : quotient;
        dterm    = dneg_reg ? -$signed(q_sat) : $signed(q_sat);
        dlim_ext = SUM_W'({1'b0, drive_limit_reg});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_axis_tvalid) state_next = S_MUL_DELTA;
            S_MUL_DELTA: state_next = S_MUL_PROP;
            S_MUL_PROP:  state_next = S_MUL_INTEG;
            S_MUL_INTEG: state_next = S_MUL_DERIV;
            S_MUL_DERIV: state_next = S_DIV_LOAD;
            S_DIV_LOAD:  state_next = S_DIV_RUN;
            S_DIV_RUN:   if (div_done) state_next = S_CLAMP;
            S_CLAMP:     if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_MUL_DELTA:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({1'b0, sample_period_reg});
            end
            S_MUL_PROP:
            begin
                mul_a = MUL_W'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            S_MUL_INTEG:
            begin
                mul_a = MUL_W'(integ_acc_reg);
                mul_b = $signed({1'b0, integ_gain_reg});
            end
            S_MUL_DERIV:
            begin
                mul_a = $signed({1'b0, mag_reg});
                mul_b = $signed({1'b0, deriv_gain_reg});
            end
            S_DIV_LOAD:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            prop_gain_reg     <= '0;
            integ_gain_reg    <= '0;
            deriv_gain_reg    <= '0;
            sample_period_reg <= RST_SAMPLE_PERIOD;
            drive_limit_reg   <= RST_DRIVE_LIMIT;
            integ_limit_reg   <= RST_INTEG_LIMIT;
            integ_acc_reg     <= '0;
            prev_error_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_data;
                    REG_INTEG_GAIN:    integ_gain_reg    <= cfg_data;
                    REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data;
                    REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data;
                    REG_DRIVE_LIMIT:   drive_limit_reg   <= cfg_data[LIM_W-1:0];
                    REG_INTEG_LIMIT:   integ_limit_reg   <= cfg_data[LIM_W-1:0];
                    default:           prop_gain_reg     <= prop_gain_reg;
                endcase
            end

            if (state_reg == S_MUL_PROP)
            begin
                if (integ_tmp > ilim_ext)
                    integ_acc_reg <= DATA_W'(ilim_ext);
                else if (integ_tmp < -ilim_ext)
                    integ_acc_reg <= DATA_W'(-ilim_ext);
                else
                    integ_acc_reg <= integ_tmp[DATA_W-1:0];
            end

            if (state_reg == S_DIV_LOAD)
                prev_error_reg <= err_reg;

            if (state_reg == S_CLAMP && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            err_reg <= err_sat;

        if (state_reg == S_MUL_DELTA)
        begin
            mag_reg  <= diff_abs[DATA_W-1:0];
            dneg_reg <= diff[DATA_W];
        end

        if (state_reg == S_MUL_PROP)
            ihit_reg <= (integ_tmp > ilim_ext) || (integ_tmp < -ilim_ext);

        case (state_reg)
            S_MUL_INTEG: sum_reg <= SUM_W'(term);
            S_MUL_DERIV: sum_reg <= sum_reg + SUM_W'(term);
            S_DIV_RUN:   if (div_done) sum_reg <= sum_reg + dterm;
            default:     sum_reg <= sum_reg;
        endcase

        if (state_reg == S_CLAMP && out_free)
        begin
            out_ihit_reg <= ihit_reg;
            if (sum_reg > dlim_ext)
            begin
                out_drive_reg <= DATA_W'(dlim_ext);
                out_dhit_reg  <= 1'b1;
            end
            else if (sum_reg < -dlim_ext)
            begin
                out_drive_reg <= DATA_W'(-dlim_ext);
                out_dhit_reg  <= 1'b1;
            end
            else
            begin
                out_drive_reg <= sum_reg[DATA_W-1:0];
                out_dhit_reg  <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_drive_reg;
    assign m_axis_tuser  = {out_ihit_reg, out_dhit_reg};

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == S_MUL_DELTA)
        else $error("accepted item did not start the sequence");

    a_div_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV_RUN)
        else $error("divider finished outside its wait state");

    a_drive_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed({1'b0, drive_limit_reg}))
                       && ($signed(m_axis_tdata) >= -$signed({1'b0, drive_limit_reg})))
        else $error("drive outside limit");

    a_clamp_flag_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
            (m_axis_tdata == DATA_W'({1'b0, drive_limit_reg}))
            || (m_axis_tdata == DATA_W'(-$signed({1'b0, drive_limit_reg}))))
        else $error("drive clamp flag without drive at limit");
`endif

endmodule

// ===== bench/pid_controller_clamped_test.sv =====
// Self-checking testbench for the clamped PID controller: directed corners and random traffic.
`timescale 1ns / 1ps

module pid_controller_clamped_test
    import pidc_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int BLOCK_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 400;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    localparam logic signed [31:0] Q_MAX    = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN    = 32'sh8000_0000;
    localparam logic [31:0]        GAIN_ONE = 32'h0100_0000;
    localparam logic [31:0]        GAIN_MAX = 32'hFFFF_FFFF;
    localparam logic [LIM_W-1:0]   LIM_MAX  = 31'h7FFF_FFFF;

    typedef enum int {CFG_RANDOM, CFG_ALL_MAX, CFG_ALL_MIN} cfg_mode_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               integ_hit;
        logic               drive_hit;
    } pid_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [63:0]          s_axis_tdata = '0;   // [31:0] setpoint, [63:32] measured
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [31:0]          m_axis_tdata;        // [31:0] drive
    logic [1:0]           m_axis_tuser;        // [0] drive_clamped, [1] integ_clamped
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;

    // controller image kept by the bench
    logic [31:0]        kp_q        = '0;
    logic [31:0]        ki_q        = '0;
    logic [31:0]        kd_q        = '0;
    logic [31:0]        period_q    = RST_SAMPLE_PERIOD;
    logic [LIM_W-1:0]   drive_lim_q = RST_DRIVE_LIMIT;
    logic [LIM_W-1:0]   integ_lim_q = RST_INTEG_LIMIT;
    logic signed [31:0] integ_q     = '0;
    logic signed [31:0] last_err_q  = '0;

    pid_result_t pending_drive_q[$];

    int src_idle   = 18;
    int sink_idle  = 68;
    int sink_hold  = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int n_items    = 0;
    int n_results  = 0;
    int n_cfg      = 0;
    int n_drive_clip = 0;
    int n_integ_clip = 0;

    pid_controller_clamped uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic pid_result_t pid_step(input logic signed [31:0] sp,
                                             input logic signed [31:0] ms);
        longint err, integ, prop, intg, der, diff, total, ilim, dlim;
        longint unsigned mag, divisor;
        pid_result_t res;
        err = longint'(sp) - longint'(ms);
        if (err > longint'(Q_MAX))
            err = longint'(Q_MAX);
        if (err < longint'(Q_MIN))
            err = longint'(Q_MIN);
        ilim = longint'({33'd0, integ_lim_q});
        dlim = longint'({33'd0, drive_lim_q});

        integ = longint'(integ_q) + ((err * longint'({32'd0, period_q})) >>> FRAC_W);
        res.integ_hit = 1'b1;
        if (integ > ilim)
            integ = ilim;
        else if (integ < -ilim)
            integ = -ilim;
        else
            res.integ_hit = 1'b0;
        integ_q = integ[31:0];

        prop = (err * longint'({32'd0, kp_q})) >>> FRAC_W;
        intg = (integ * longint'({32'd0, ki_q})) >>> FRAC_W;

        // derivative on magnitude, truncated toward zero
        diff = err - longint'(last_err_q);
        mag = (diff < 0) ? -diff : diff;
        mag = mag * {32'd0, kd_q};
        divisor = (period_q == 32'd0) ? 64'd1 : {32'd0, period_q};
        mag = mag / divisor;
        if (mag > D_SAT)
            mag = D_SAT;
        der = (diff < 0) ? -longint'(mag) : longint'(mag);
        last_err_q = err[31:0];

        total = prop + intg + der;
        res.drive_hit = 1'b1;
        if (total > dlim)
            total = dlim;
        else if (total < -dlim)
            total = -dlim;
        else
            res.drive_hit = 1'b0;
        res.drive = total[31:0];
        return res;
    endfunction

    task automatic send_sample(input logic signed [31:0] sp, input logic signed [31:0] ms);
        @(negedge clk);
        while ($urandom_range(99) < src_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ms, sp};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_drive_q.push_back(pid_step(sp, ms));
        n_items++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_PROP_GAIN:     kp_q = value;
            REG_INTEG_GAIN:    ki_q = value;
            REG_DERIV_GAIN:    kd_q = value;
            REG_SAMPLE_PERIOD: period_q = value;
            REG_DRIVE_LIMIT:   drive_lim_q = value[LIM_W-1:0];
            REG_INTEG_LIMIT:   integ_lim_q = value[LIM_W-1:0];
            default: ;
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] kp, input logic [31:0] ki,
                                input logic [31:0] kd, input logic [31:0] period,
                                input logic [LIM_W-1:0] dlim, input logic [LIM_W-1:0] ilim);
        cfg_write(REG_PROP_GAIN, kp);
        cfg_write(REG_INTEG_GAIN, ki);
        cfg_write(REG_DERIV_GAIN, kd);
        cfg_write(REG_SAMPLE_PERIOD, period);
        cfg_write(REG_DRIVE_LIMIT, {1'b0, dlim});
        cfg_write(REG_INTEG_LIMIT, {1'b0, ilim});
    endtask

    // stop offering, wait for every pending result, then let the sequencer settle
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_drive_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(7))
            0: return 32'd0;
            1: return GAIN_MAX;
            2, 3: return $urandom;
            default: return $urandom_range(32'h0400_0000);
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(7))
            0: return 32'd1;
            1: return GAIN_MAX;
            2: return $urandom;
            default: return $urandom_range(32'h0040_0000, 1);
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] pick_limit();
        case ($urandom_range(7))
            0: return '0;
            1: return LIM_MAX;
            2: return LIM_W'($urandom >> 1);
            default: return LIM_W'($urandom_range(32'h0400_0000, 1));
        endcase
    endfunction

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(4))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic load_config(input cfg_mode_t mode);
        if (mode == CFG_ALL_MAX)
            apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIM_MAX, LIM_MAX);
        else if (mode == CFG_ALL_MIN)
            apply_config('0, '0, '0, 32'd1, '0, '0);
        else
            apply_config(pick_gain(), pick_gain(), pick_gain(), pick_period(),
                         pick_limit(), pick_limit());
        if ($urandom_range(3) == 0)
            cfg_write($urandom_range(1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom);
    endtask

    // mostly a loop tracking a slowly moving target, plus raw noise and extremes
    task automatic run_samples(input int count);
        logic signed [31:0] target, sp, ms;
        target = $signed($urandom) >>> $urandom_range(12, 4);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(19))
                0, 1, 2:
                begin
                    sp = $urandom;
                    ms = $urandom;
                end
                3:
                begin
                    sp = extreme_value();
                    ms = extreme_value();
                end
                default:
                begin
                    if ($urandom_range(15) == 0)
                        target = $signed($urandom) >>> $urandom_range(12, 0);
                    sp = target;
                    ms = target - ($signed($urandom) >>> $urandom_range(30, 6));
                end
            endcase
            send_sample(sp, ms);
        end
    endtask

    task automatic test_power_on_defaults();
        send_sample(32'sd0, 32'sd0);
        send_sample(32'sh0001_0000, 32'sd0);
        send_sample(Q_MAX, Q_MIN);
        send_sample(Q_MIN, Q_MAX);
        drain();
    endtask

    task automatic test_clamp_boundaries();
        apply_config(GAIN_ONE, '0, '0, GAIN_ONE, 31'h0001_0000, 31'h0002_0000);
        send_sample(32'sh0001_0000, 32'sd0);
        send_sample(32'sh0001_0001, 32'sd0);
        send_sample(32'sd0, 32'sh0001_0000);
        send_sample(32'sd0, 32'sh0001_0001);
        // land the integral exactly on each limit, then one step past it
        send_sample(32'sh0002_0000 - integ_q, 32'sd0);
        send_sample(32'sd1, 32'sd0);
        send_sample(32'sd0, 32'sh0002_0000 + integ_q);
        send_sample(32'sd0, 32'sd1);
        drain();
        apply_config(GAIN_ONE, GAIN_ONE, '0, GAIN_ONE, '0, '0);
        send_sample(32'sd0, 32'sd0);
        send_sample(32'sd5, 32'sd0);
        drain();
    endtask

    task automatic test_zero_period();
        apply_config(GAIN_ONE, GAIN_ONE, GAIN_ONE, 32'd0, LIM_MAX, LIM_MAX);
        send_sample(32'sh0003_0000, 32'sd0);
        send_sample(-32'sh0005_0000, 32'sh0000_8000);
        send_sample(Q_MAX, Q_MIN);
        drain();
    endtask

    task automatic test_unmapped_index();
        cfg_write(REG_UNMAPPED_LO, $urandom);
        cfg_write(REG_UNMAPPED_HI, GAIN_MAX);
        send_sample(32'sh0000_4000, 32'sh0000_1000);
        send_sample(32'sd0, 32'sh0000_2000);
        drain();
    endtask

    task automatic test_gain_extremes();
        apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, 32'd1, LIM_MAX, LIM_MAX);
        send_sample(Q_MAX, Q_MIN);
        send_sample(Q_MIN, Q_MAX);
        send_sample(Q_MIN, Q_MAX);
        send_sample(32'sd0, 32'sd0);
        drain();
        apply_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, LIM_MAX, LIM_MAX);
        send_sample(Q_MAX, Q_MIN);
        send_sample(32'sd1, 32'sd0);
        drain();
    endtask

    task automatic test_output_backpressure();
        apply_config(32'h0080_0000, 32'h0010_0000, 32'h0000_4000, RST_SAMPLE_PERIOD,
                     RST_DRIVE_LIMIT, RST_INTEG_LIMIT);
        sink_hold = HOLD_CYCLES;
        run_samples(12);
        drain();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle  = (phase == 0) ? 18 : (phase == 1) ? 68 : 0;
            sink_idle = (phase == 0) ? 68 : (phase == 1) ? 18 : 0;
            for (int blk = 0; blk < 6; blk++)
            begin
                drain();
                if (phase == 0 && blk == 0)
                    load_config(CFG_ALL_MAX);
                else if (phase == 0 && blk == 1)
                    load_config(CFG_ALL_MIN);
                else
                    load_config(CFG_RANDOM);
                run_samples(BLOCK_ITEMS);
            end
        end
        drain();
    endtask

    // sink side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    always @(posedge clk)
    begin : result_check
        pid_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            n_results++;
            n_drive_clip += m_axis_tuser[0];
            n_integ_clip += m_axis_tuser[1];
            if (pending_drive_q.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("Unexpected result %0d: drive %h flags %b",
                             n_results, m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_drive_q.pop_front();
                if (want.drive !== m_axis_tdata || want.drive_hit !== m_axis_tuser[0]
                    || want.integ_hit !== m_axis_tuser[1])
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("Mismatch on result %0d: expected drive %h flags %b%b, got %h %b",
                                 n_results, want.drive, want.integ_hit, want.drive_hit,
                                 m_axis_tdata, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_clamp_boundaries();
        test_zero_period();
        test_unmapped_index();
        test_gain_extremes();
        test_output_backpressure();
        test_random_traffic();

        repeat (50) @(posedge clk);
        if (pending_drive_q.size() != 0)
            mismatches++;
        $display("Ran %0d samples and %0d register writes over three stall profiles",
                 n_items, n_cfg);
        $display("Results %0d, drive clamped %0d, integral clamped %0d, mismatches %0d",
                 n_results, n_drive_clip, n_integ_clip, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pidc_pkg.sv
rtl/core/pidc_mul.sv
rtl/core/pidc_div.sv
rtl/core/pid_controller_clamped.sv
bench/pid_controller_clamped_test.sv
